// ----- src/bol_pkg.sv -----
// Package with the operation and status codes of the ordered list.
`default_nettype none
package bol_pkg;
  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_DEL_HEAD = 3'd1;
  localparam logic [2:0] OP_INS_TAIL = 3'd2;
  localparam logic [2:0] OP_DEL_TAIL = 3'd3;
  localparam logic [2:0] OP_DEL_KEY  = 3'd4;
  localparam logic [2:0] OP_INS_KEY  = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_INS   = 2'd1,
    CMD_DEL   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic      load;
    cmd_kind_t kind;
  } ctl_t;
endpackage
`default_nettype wire

// ----- src/bol_datapath.sv -----
// Datapath: a row of element cells that compare against the key and shift.
`default_nettype none
module bol_datapath import bol_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_t              ctl,
  input  wire logic [CW-1:0]     pos,
  input  wire logic [31:0]       value,
  input  wire logic [31:0]       key,
  output logic [CAPACITY-1:0]    match,
  output logic [CW-1:0]          count
);
  logic [31:0]   cell_r [CAPACITY];
  logic [CW-1:0] count_r;

  assign count = count_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (cell_r[i] == key) && (CW'(i) < count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (ctl.kind == CMD_INS) begin
          if (CW'(i) == pos) begin
            cell_r[i] <= value;
          end else if (CW'(i) > pos && i > 0) begin
            cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
          end
        end else if (ctl.kind == CMD_DEL) begin
          if (CW'(i) >= pos && i < CAPACITY - 1) begin
            cell_r[i] <= cell_r[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.load) begin
      case (ctl.kind)
        CMD_INS: count_r <= count_r + CW'(1);
        CMD_DEL: count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/bol_ctrl.sv -----
// Controller: decodes the operation, checks status and drives the datapath.
`default_nettype none
module bol_ctrl import bol_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [2:0]        op,
  input  wire logic [CAPACITY-1:0] match,
  input  wire logic [CW-1:0]     count,
  output ctl_t                   ctl,
  output logic [CW-1:0]          pos,
  output logic                   busy,
  output logic                   done_r,
  output logic [1:0]             status_r
);
  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t        state_r;
  logic          empty, full, found;
  logic [CW-1:0] first;
  logic [1:0]    status_nxt;

  assign busy = 1'b0;
  assign empty = (count == '0);
  assign full = (count >= CW'(CAPACITY));
  assign found = |match;

  always_comb begin
    first = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) first = CW'(i);
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    ctl.kind = CMD_NONE;
    pos = '0;
    case (op)
      OP_INS_HEAD: if (full) status_nxt = ST_FULL; else ctl.kind = CMD_INS;
      OP_DEL_HEAD: if (empty) status_nxt = ST_EMPTY; else ctl.kind = CMD_DEL;
      OP_INS_TAIL: begin
        pos = count;
        if (full) status_nxt = ST_FULL; else ctl.kind = CMD_INS;
      end
      OP_DEL_TAIL: begin
        pos = count - CW'(1);
        if (empty) status_nxt = ST_EMPTY; else ctl.kind = CMD_DEL;
      end
      OP_DEL_KEY: begin
        pos = first;
        if (empty) status_nxt = ST_EMPTY;
        else if (!found) status_nxt = ST_NOTFOUND;
        else ctl.kind = CMD_DEL;
      end
      OP_INS_KEY: begin
        pos = first;
        if (empty) status_nxt = ST_EMPTY;
        else if (full) status_nxt = ST_FULL;
        else if (!found) status_nxt = ST_NOTFOUND;
        else ctl.kind = CMD_INS;
      end
      default: ;
    endcase
    ctl.load = start && (state_r == S_RUN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      done_r  <= 1'b0;
    end else begin
      state_r <= S_RUN;
      done_r  <= ctl.load;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end
endmodule
`default_nettype wire

// ----- src/bounded_ordered_list.sv -----
// Top level of the bounded ordered list.
// The result of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle; busy stays low, every cell compares and shifts at once.
// Reset clears the element count; the element cells hold no reset value.
// The receiver cannot stall: each result shows for one cycle under out_valid.
`default_nettype none
module bounded_ordered_list import bol_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic signed [31:0] in_search_key,
  input  wire logic signed [31:0] in_new_value,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [4:0]       out_element_count,
  output logic             out_is_empty
);
  localparam int CW = $clog2(CAPACITY + 1);

  ctl_t                ctl;
  logic [CW-1:0]       pos, count;
  logic [CAPACITY-1:0] match;

  bol_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk, .rst_n, .start, .op(in_operation), .match, .count,
    .ctl, .pos, .busy, .done_r(out_valid), .status_r(out_status)
  );

  bol_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .ctl, .pos, .value(in_new_value), .key(in_search_key),
    .match, .count
  );

  assign out_element_count = 5'(count);
  assign out_is_empty = (count == '0);
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the bounded ordered list: directed and random operations.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import bol_pkg::*;

  localparam int CAPACITY = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_operation = OP_INS_HEAD;
  logic signed [31:0] in_search_key = '0;
  logic signed [31:0] in_new_value = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [4:0] out_element_count;
  logic out_is_empty;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] element_count;
    logic       is_empty;
  } list_result_t;

  logic [31:0] list_model[$];
  list_result_t pending_results[$];
  int mismatch_count = 0;
  int idle_percent = 8;

  bounded_ordered_list #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_search_key(in_search_key),
    .in_new_value(in_new_value), .out_valid(out_valid), .out_status(out_status),
    .out_element_count(out_element_count), .out_is_empty(out_is_empty)
  );

  always #5 clk = ~clk;

  function automatic int find_first(logic [31:0] key);
    for (int i = 0; i < list_model.size(); i++) begin
      if (list_model[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic list_result_t apply_operation(logic [2:0] op, logic [31:0] key,
                                                   logic [31:0] value);
    list_result_t r;
    int pos;
    bit is_full;
    bit is_none;
    is_full = list_model.size() >= CAPACITY;
    is_none = list_model.size() == 0;
    r.status = ST_DONE;
    case (op)
      OP_INS_HEAD: begin
        if (is_full) r.status = ST_FULL;
        else list_model.push_front(value);
      end
      OP_DEL_HEAD: begin
        if (is_none) r.status = ST_EMPTY;
        else void'(list_model.pop_front());
      end
      OP_INS_TAIL: begin
        if (is_full) r.status = ST_FULL;
        else list_model.push_back(value);
      end
      OP_DEL_TAIL: begin
        if (is_none) r.status = ST_EMPTY;
        else void'(list_model.pop_back());
      end
      OP_DEL_KEY: begin
        pos = find_first(key);
        if (is_none) r.status = ST_EMPTY;
        else if (pos < 0) r.status = ST_NOTFOUND;
        else list_model.delete(pos);
      end
      OP_INS_KEY: begin
        pos = find_first(key);
        if (is_none) r.status = ST_EMPTY;
        else if (is_full) r.status = ST_FULL;
        else if (pos < 0) r.status = ST_NOTFOUND;
        else list_model.insert(pos, value);
      end
      default: ;
    endcase
    r.element_count = 5'(list_model.size());
    r.is_empty = list_model.size() == 0;
    return r;
  endfunction

  task automatic send_item(logic [2:0] op, logic [31:0] key, logic [31:0] value);
    while ($urandom_range(99) < idle_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_search_key <= key;
    in_new_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_operation(op, key, value));
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result at %0t", $time);
      end else begin
        list_result_t want;
        want = pending_results.pop_front();
        if (want != {out_status, out_element_count, out_is_empty}) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected status %0d count %0d empty %0d, got %0d %0d %0d",
                     want.status, want.element_count, want.is_empty,
                     out_status, out_element_count, out_is_empty);
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    if (list_model.size() != 0 && $urandom_range(3) == 0)
      return list_model[$urandom_range(list_model.size() - 1)];
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_list();
    for (int op = 0; op < 8; op++) send_item(3'(op), 32'h0, 32'h0);
    send_item(OP_DEL_TAIL, 0, 0);
  endtask

  task automatic test_fill_and_full();
    send_item(OP_INS_TAIL, 0, 32'h8000_0000);
    send_item(OP_INS_HEAD, 0, 32'h7fff_ffff);
    send_item(OP_INS_KEY, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(OP_INS_KEY, 32'h8000_0000, 32'h5555_5555);
    send_item(OP_INS_KEY, 32'h1234_5678, 32'haaaa_aaaa);
    send_item(OP_DEL_KEY, 32'h1234_5678, 0);
    while (list_model.size() < CAPACITY) send_item(OP_INS_TAIL, 0, 32'h7fff_ffff);
    send_item(OP_INS_HEAD, 0, 1);
    send_item(OP_INS_TAIL, 0, 1);
    send_item(OP_INS_KEY, 32'h7fff_ffff, 1);
    send_item(OP_DEL_KEY, 32'h7fff_ffff, 0);
    send_item(OP_DEL_HEAD, 0, 0);
    send_item(3'd7, 0, 0);
    drain_results();
  endtask

  task automatic test_random_operations(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      idle_percent = (i >= count / 4 && i < count / 4 + 100) ? 0 : 8;
      op = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      if (list_model.size() > 12 && $urandom_range(1)) op = OP_DEL_KEY;
      send_item(op, pick_value(), pick_value());
    end
    while (list_model.size() > 0) send_item(OP_DEL_HEAD, 0, 0);
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_and_full();
    test_random_operations(500);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
